// File: design/mdk_pkg.sv
// Shared types, codes and marker constants for the marker deframer with keepalive.
`timescale 1ns / 1ps

package mdk_pkg;

    localparam int HIST_LEN  = 11;
    localparam int END_LEN   = 10;
    localparam int CFG_WIDTH = 17;

    localparam logic [3:0]  COUNT_SAT = 4'd12;
    localparam logic [16:0] AGE_MAX   = 17'h1FFFF;

    // Input opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_PING    = 2'd2;
    localparam logic [1:0] KIND_ABORT   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_PING_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_PONG_TIMEOUT  = 2'd1;
    localparam logic [1:0] CFG_GREETING_TYPE = 2'd2;
    localparam logic [1:0] CFG_PONG_TYPE     = 2'd3;

    localparam logic [15:0] PING_INTERVAL_RESET = 16'(5 * 1000);
    localparam logic [16:0] PONG_TIMEOUT_RESET  = 17'(60 * 1000);
    localparam logic [7:0]  GREETING_TYPE_RESET = 8'h00;
    localparam logic [7:0]  PONG_TYPE_RESET     = 8'h03;

    // Markers in order of arrival, first byte at index 0.
    localparam logic [7:0] START_MARK [HIST_LEN] = '{
        8'h01, 8'h50, 8'h02, 8'h50, 8'h5F, 8'h53, 8'h54, 8'h41, 8'h52, 8'h54, 8'h17
    };
    localparam logic [7:0] END_MARK [END_LEN] = '{
        8'h01, 8'h50, 8'h02, 8'h50, 8'h5F, 8'h45, 8'h4E, 8'h44, 8'h17, 8'h04
    };

    typedef struct packed {
        logic [15:0] ping_interval_ticks;
        logic [16:0] pong_timeout_ticks;
        logic [7:0]  greeting_type_code;
        logic [7:0]  pong_type_code;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic [7:0] frame_type;
        logic       type_ok;
        logic       last_of_step;
    } result_t;

endpackage

// File: design/mdk_ifs.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface mdk_item_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface mdk_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [7:0] frame_type;
    logic       type_ok;
    logic       last_of_step;

    modport source (output valid, output kind, output payload_byte, output frame_type,
                    output type_ok, output last_of_step, input ready);
    modport sink (input valid, input kind, input payload_byte, input frame_type,
                  input type_ok, input last_of_step, output ready);
endinterface

// File: design/mdk_engine.sv
// Input register, deframing and keepalive state, and the per-item result logic.
`timescale 1ns / 1ps

module mdk_engine (
    input  logic            clk,
    input  logic            rst_n,
    mdk_item_if.sink        items,
    input  mdk_pkg::cfg_t   cfg,
    input  logic            buf_ready,
    output logic            push,
    output mdk_pkg::result_t push_data
);

    logic       item_valid_reg;
    logic       item_op_reg;
    logic [7:0] item_byte_reg;
    logic       advance;

    logic        in_frame_reg, in_frame_next;
    logic [7:0]  hist_reg [mdk_pkg::HIST_LEN];
    logic [7:0]  hist_next [mdk_pkg::HIST_LEN];
    logic [3:0]  count_reg, count_next;
    logic [7:0]  type_reg, type_next;
    logic        link_reg, link_next;
    logic [15:0] ping_cnt_reg, ping_cnt_next;
    logic [16:0] age_reg, age_next;

    logic        start_hit;
    logic        end_hit;
    logic [3:0]  count_inc;
    logic [16:0] age_inc;
    logic        type_ok;
    logic        has_result;
    mdk_pkg::result_t res;

    assign items.ready = !item_valid_reg || buf_ready;
    assign advance     = item_valid_reg && buf_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            item_valid_reg <= 1'b0;
        end
        else if (items.ready) begin
            item_valid_reg <= items.valid;
        end
    end

    always_ff @(posedge clk) begin
        if (items.ready && items.valid) begin
            item_op_reg   <= items.opcode;
            item_byte_reg <= items.rx_byte;
        end
    end

    // The history after this byte has been shifted in; index 0 is the newest.
    always_comb begin
        hist_next[0] = item_byte_reg;
        for (int i = 1; i < mdk_pkg::HIST_LEN; i++) begin
            hist_next[i] = hist_reg[i - 1];
        end
    end

    always_comb begin
        start_hit = 1'b1;
        for (int i = 0; i < mdk_pkg::HIST_LEN; i++) begin
            if (hist_next[mdk_pkg::HIST_LEN - 1 - i] != mdk_pkg::START_MARK[i]) begin
                start_hit = 1'b0;
            end
        end
        end_hit = 1'b1;
        for (int i = 0; i < mdk_pkg::END_LEN; i++) begin
            if (hist_next[mdk_pkg::END_LEN - 1 - i] != mdk_pkg::END_MARK[i]) begin
                end_hit = 1'b0;
            end
        end
    end

    assign count_inc = (count_reg < mdk_pkg::COUNT_SAT) ? count_reg + 4'd1 : count_reg;
    assign age_inc   = (age_reg < mdk_pkg::AGE_MAX) ? age_reg + 17'd1 : age_reg;
    assign type_ok   = (hist_next[mdk_pkg::HIST_LEN - 1] == type_reg);

    always_comb begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        type_next     = type_reg;
        link_next     = link_reg;
        ping_cnt_next = ping_cnt_reg;
        age_next      = age_reg;
        has_result    = 1'b0;
        res           = '0;
        res.last_of_step = 1'b1;

        if (item_op_reg == mdk_pkg::OP_TICK) begin
            if (link_reg) begin
                age_next = age_inc;
                if ({1'b0, ping_cnt_reg} + 17'd1 >= {1'b0, cfg.ping_interval_ticks}) begin
                    ping_cnt_next = '0;
                    has_result    = 1'b1;
                    if (age_inc > cfg.pong_timeout_ticks) begin
                        link_next = 1'b0;
                        res.kind  = mdk_pkg::KIND_ABORT;
                    end
                    else begin
                        res.kind = mdk_pkg::KIND_PING;
                    end
                end
                else begin
                    ping_cnt_next = ping_cnt_reg + 16'd1;
                end
            end
        end
        else if (!in_frame_reg) begin
            if (start_hit) begin
                in_frame_next = 1'b1;
                count_next    = '0;
            end
        end
        else begin
            count_next = count_inc;
            if (count_inc >= 4'd10 && end_hit) begin
                in_frame_next = 1'b0;
                count_next    = '0;
                // An empty body closes the frame silently.
                if (count_inc >= 4'd11) begin
                    has_result    = 1'b1;
                    res.kind      = mdk_pkg::KIND_END;
                    res.frame_type = type_reg;
                    res.type_ok   = type_ok;
                    if (type_ok) begin
                        if (type_reg == cfg.greeting_type_code) begin
                            link_next     = 1'b1;
                            ping_cnt_next = '0;
                            age_next      = '0;
                        end
                        if (type_reg == cfg.pong_type_code) begin
                            age_next = '0;
                        end
                    end
                end
            end
            else if (count_inc == 4'd10) begin
                type_next = hist_next[mdk_pkg::END_LEN - 1];
            end
            else if (count_inc >= mdk_pkg::COUNT_SAT) begin
                has_result       = 1'b1;
                res.kind         = mdk_pkg::KIND_PAYLOAD;
                res.payload_byte = hist_next[mdk_pkg::HIST_LEN - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_frame_reg <= 1'b0;
            for (int i = 0; i < mdk_pkg::HIST_LEN; i++) begin
                hist_reg[i] <= '0;
            end
            count_reg    <= '0;
            type_reg     <= '0;
            link_reg     <= 1'b0;
            ping_cnt_reg <= '0;
            age_reg      <= '0;
        end
        else if (advance) begin
            in_frame_reg <= in_frame_next;
            if (item_op_reg == mdk_pkg::OP_BYTE) begin
                for (int i = 0; i < mdk_pkg::HIST_LEN; i++) begin
                    hist_reg[i] <= hist_next[i];
                end
            end
            count_reg    <= count_next;
            type_reg     <= type_next;
            link_reg     <= link_next;
            ping_cnt_reg <= ping_cnt_next;
            age_reg      <= age_next;
        end
    end

    assign push      = advance && has_result;
    assign push_data = res;

    a_count_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != 4'd0) |-> in_frame_reg)
        else $error("body count is nonzero while hunting");

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mdk_pkg::COUNT_SAT)
        else $error("body count passed its saturation value");

    a_end_leaves_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_data.kind == mdk_pkg::KIND_END) |=> !in_frame_reg)
        else $error("frame end reported but the block did not return to hunting");

    a_keepalive_needs_link: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (push_data.kind == mdk_pkg::KIND_PING ||
                  push_data.kind == mdk_pkg::KIND_ABORT)) |-> link_reg)
        else $error("keepalive result while the keepalive is stopped");

endmodule

// File: design/mdk_out_buf.sv
// Result register with a skid entry, so that the engine keeps going through a stall.
`timescale 1ns / 1ps

module mdk_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mdk_pkg::result_t push_data,
    output logic             buf_ready,
    mdk_result_if.source     results
);

    logic             main_valid_reg;
    mdk_pkg::result_t main_data_reg;
    logic             skid_valid_reg;
    mdk_pkg::result_t skid_data_reg;
    logic             pop;

    assign buf_ready = !skid_valid_reg;
    assign pop       = main_valid_reg && results.ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || pop) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else begin
                main_valid_reg <= push;
            end
        end
        else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (!main_valid_reg || pop) begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push) begin
            skid_data_reg <= push_data;
        end
    end

    assign results.valid        = main_valid_reg;
    assign results.kind         = main_data_reg.kind;
    assign results.payload_byte = main_data_reg.payload_byte;
    assign results.frame_type   = main_data_reg.frame_type;
    assign results.type_ok      = main_data_reg.type_ok;
    assign results.last_of_step = main_data_reg.last_of_step;

    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry holds an item while the result register is empty");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> buf_ready)
        else $error("item pushed into a full result buffer");

endmodule

// File: design/marker_deframer_with_keepalive_core.sv
// Top level of the marker deframer with keepalive: configuration registers and datapath.
//
//  Channel   Direction  Carries
//  items     in         opcode (byte or tick), rx_byte
//  results   out        kind, payload_byte, frame_type, type_ok, last_of_step
//  cfg_*     in         write enable, register index, write data
//
// One item is taken every clock cycle while the skid entry is empty; an item waits in the
// input register and its result in the result register. The per-item state update is a
// single pass of marker compares and small counters. Reset loads the register defaults and
// returns the deframer to hunting with the keepalive stopped. A skid entry behind the
// result register keeps items flowing through an output stall until it fills, after which
// items.ready drops until the result register drains.
`timescale 1ns / 1ps

module marker_deframer_with_keepalive_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [mdk_pkg::CFG_WIDTH-1:0] cfg_data,
    mdk_item_if.sink                      items,
    mdk_result_if.source                  results
);

    mdk_pkg::cfg_t    cfg_reg;
    logic             push;
    mdk_pkg::result_t push_data;
    logic             buf_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.ping_interval_ticks <= mdk_pkg::PING_INTERVAL_RESET;
            cfg_reg.pong_timeout_ticks  <= mdk_pkg::PONG_TIMEOUT_RESET;
            cfg_reg.greeting_type_code  <= mdk_pkg::GREETING_TYPE_RESET;
            cfg_reg.pong_type_code      <= mdk_pkg::PONG_TYPE_RESET;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                mdk_pkg::CFG_PING_INTERVAL: cfg_reg.ping_interval_ticks <= cfg_data[15:0];
                mdk_pkg::CFG_PONG_TIMEOUT:  cfg_reg.pong_timeout_ticks  <= cfg_data[16:0];
                mdk_pkg::CFG_GREETING_TYPE: cfg_reg.greeting_type_code  <= cfg_data[7:0];
                mdk_pkg::CFG_PONG_TYPE:     cfg_reg.pong_type_code      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    mdk_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .cfg       (cfg_reg),
        .buf_ready (buf_ready),
        .push      (push),
        .push_data (push_data)
    );

    mdk_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .buf_ready (buf_ready),
        .results   (results)
    );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the marker deframer with keepalive: predictor, stimulus, checks.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [1:0]                    cfg_index;
    logic [mdk_pkg::CFG_WIDTH-1:0] cfg_data;

    mdk_item_if   item_ch ();
    mdk_result_if res_ch ();

    marker_deframer_with_keepalive_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (item_ch),
        .results   (res_ch)
    );

    // Predicted state of the deframer and the keepalive timer.
    mdk_pkg::cfg_t link_cfg;
    bit            framing;
    logic [7:0]    recent [mdk_pkg::HIST_LEN];
    logic [3:0]    body_len;
    logic [7:0]    open_type;
    bit            keepalive_on;
    logic [15:0]   ticks_since_ping;
    logic [16:0]   pong_age;

    mdk_pkg::result_t pending_results [$];
    int               mismatches = 0;
    int               items_done = 0;
    int               tick_pct = 0;
    int               hold_left = 0;
    bit               src_idle = 1'b1;
    bit               snk_idle = 1'b1;
    int unsigned      cycle_count = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Long receiver hold-off, counted down here once a test loads it.
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    function automatic string show(input mdk_pkg::result_t r);
        return $sformatf("kind %0d payload %02h type %02h ok %0d last %0d",
                         r.kind, r.payload_byte, r.frame_type, r.type_ok, r.last_of_step);
    endfunction

    function automatic void log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("tb_top: mismatch at cycle %0d: %s", cycle_count, msg);
    endfunction

    // Applies one accepted item to the predicted state and queues the results it causes.
    // Returns 0 for an item the block ignores outright (a tick with the keepalive stopped).
    function automatic bit advance_link(input logic op, input logic [7:0] b);
        mdk_pkg::result_t r;
        bit               hit;
        bit               has_body;
        r = '0;
        r.last_of_step = 1'b1;
        if (op == mdk_pkg::OP_TICK)
        begin
            if (!keepalive_on)
                return 1'b0;
            if (pong_age != mdk_pkg::AGE_MAX)
                pong_age = pong_age + 17'd1;
            if ({1'b0, ticks_since_ping} + 17'd1 >= {1'b0, link_cfg.ping_interval_ticks})
            begin
                ticks_since_ping = '0;
                if (pong_age > link_cfg.pong_timeout_ticks)
                begin
                    keepalive_on = 1'b0;
                    r.kind = mdk_pkg::KIND_ABORT;
                end
                else
                    r.kind = mdk_pkg::KIND_PING;
                pending_results.push_back(r);
            end
            else
                ticks_since_ping = ticks_since_ping + 16'd1;
            return 1'b1;
        end

        for (int i = mdk_pkg::HIST_LEN - 1; i > 0; i--)
            recent[i] = recent[i - 1];
        recent[0] = b;

        if (!framing)
        begin
            hit = 1'b1;
            for (int i = 0; i < mdk_pkg::HIST_LEN; i++)
                if (recent[mdk_pkg::HIST_LEN - 1 - i] != mdk_pkg::START_MARK[i])
                    hit = 1'b0;
            if (hit)
            begin
                framing  = 1'b1;
                body_len = '0;
            end
            return 1'b1;
        end

        if (body_len < mdk_pkg::COUNT_SAT)
            body_len = body_len + 4'd1;
        hit = 1'b1;
        for (int i = 0; i < mdk_pkg::END_LEN; i++)
            if (recent[mdk_pkg::END_LEN - 1 - i] != mdk_pkg::END_MARK[i])
                hit = 1'b0;

        if (body_len >= mdk_pkg::END_LEN && hit)
        begin
            has_body = body_len >= mdk_pkg::END_LEN + 1;
            framing  = 1'b0;
            body_len = '0;
            if (has_body)
            begin
                r.kind       = mdk_pkg::KIND_END;
                r.frame_type = open_type;
                r.type_ok    = recent[mdk_pkg::HIST_LEN - 1] == open_type;
                if (r.type_ok)
                begin
                    if (open_type == link_cfg.greeting_type_code)
                    begin
                        keepalive_on     = 1'b1;
                        ticks_since_ping = '0;
                        pong_age         = '0;
                    end
                    if (open_type == link_cfg.pong_type_code)
                        pong_age = '0;
                end
                pending_results.push_back(r);
            end
        end
        else if (body_len == mdk_pkg::END_LEN)
            open_type = recent[mdk_pkg::END_LEN - 1];
        else if (body_len == mdk_pkg::COUNT_SAT)
        begin
            // The oldest held byte can no longer be part of an end marker.
            r.kind         = mdk_pkg::KIND_PAYLOAD;
            r.payload_byte = recent[mdk_pkg::HIST_LEN - 1];
            pending_results.push_back(r);
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] body_byte_pick();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25)
            return mdk_pkg::END_MARK[$urandom_range(mdk_pkg::END_LEN - 1)];
        if (pick < 30)
            return mdk_pkg::START_MARK[$urandom_range(mdk_pkg::HIST_LEN - 1)];
        return 8'($urandom);
    endfunction

    // Valid is left high after acceptance; the next call either lowers it or keeps it up.
    task automatic send_item(input logic op, input logic [7:0] b);
        while (src_idle && $urandom_range(99) < 19)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.opcode  <= op;
        item_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!item_ch.ready);
        if (advance_link(op, b))
            items_done++;
    endtask

    task automatic send_frame(input logic [7:0] body[$]);
        for (int i = 0; i < mdk_pkg::HIST_LEN; i++)
            send_item(mdk_pkg::OP_BYTE, mdk_pkg::START_MARK[i]);
        foreach (body[i])
        begin
            if ($urandom_range(99) < tick_pct)
                send_item(mdk_pkg::OP_TICK, 8'($urandom));
            send_item(mdk_pkg::OP_BYTE, body[i]);
        end
        for (int i = 0; i < mdk_pkg::END_LEN; i++)
            send_item(mdk_pkg::OP_BYTE, mdk_pkg::END_MARK[i]);
    endtask

    // Stops the input and lets any result still in flight come out before a register write.
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx,
                             input logic [mdk_pkg::CFG_WIDTH-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] interval, input logic [16:0] timeout,
                              input logic [7:0] greet, input logic [7:0] pong);
        drain_results();
        write_reg(mdk_pkg::CFG_PING_INTERVAL, mdk_pkg::CFG_WIDTH'(interval));
        write_reg(mdk_pkg::CFG_PONG_TIMEOUT, timeout);
        write_reg(mdk_pkg::CFG_GREETING_TYPE, mdk_pkg::CFG_WIDTH'(greet));
        write_reg(mdk_pkg::CFG_PONG_TYPE, mdk_pkg::CFG_WIDTH'(pong));
        cfg_we <= 1'b0;
        link_cfg.ping_interval_ticks = interval;
        link_cfg.pong_timeout_ticks  = timeout;
        link_cfg.greeting_type_code  = greet;
        link_cfg.pong_type_code      = pong;
    endtask

    task automatic test_reset_defaults();
        logic [7:0] body[$];
        send_item(mdk_pkg::OP_TICK, 8'h00);
        body = {mdk_pkg::GREETING_TYPE_RESET};
        send_frame(body);
        src_idle = 1'b0;
        repeat (20) send_item(mdk_pkg::OP_TICK, 8'($urandom));
        body = {mdk_pkg::PONG_TYPE_RESET, mdk_pkg::PONG_TYPE_RESET};
        send_frame(body);
        // The default interval is far longer than this, so no ping is due yet.
        repeat (20) send_item(mdk_pkg::OP_TICK, 8'($urandom));
        src_idle = 1'b1;
    endtask

    task automatic test_frame_cases();
        logic [7:0] body[$];
        set_config(16'd3, 17'd5, 8'hA5, 8'h5A);
        send_item(mdk_pkg::OP_TICK, 8'hFF);
        send_item(mdk_pkg::OP_BYTE, 8'h00);
        send_item(mdk_pkg::OP_BYTE, 8'hFF);
        body.delete();
        send_frame(body);
        // A one-byte body is both type and closing byte; here it is a greeting.
        body = {8'hA5};
        send_frame(body);
        // Pong type with a wrong closing byte must not clear the pong age.
        body = {8'h5A, 8'h00, 8'hFF, 8'h00};
        send_frame(body);
        repeat (7) send_item(mdk_pkg::OP_TICK, 8'($urandom));
        body = {8'h5A, 8'h5A};
        send_frame(body);
        body = {8'h77};
        for (int i = 0; i < mdk_pkg::HIST_LEN; i++)
            body.push_back(mdk_pkg::START_MARK[i]);
        body.push_back(8'h77);
        send_frame(body);

        set_config(16'd3, 17'd5, 8'h66, 8'h66);
        body = {8'h66, 8'h01, 8'h66};
        send_frame(body);
        repeat (4) send_item(mdk_pkg::OP_TICK, 8'($urandom));

        set_config(16'd100, 17'd1000, 8'hA5, 8'h5A);
        repeat (40) send_item(mdk_pkg::OP_TICK, 8'($urandom));
        set_config(16'd10, 17'd1000, 8'hA5, 8'h5A);
        send_item(mdk_pkg::OP_TICK, 8'h00);
        set_config(16'd0, 17'd1000, 8'hA5, 8'h5A);
        repeat (3) send_item(mdk_pkg::OP_TICK, 8'($urandom));
    endtask

    task automatic test_output_stall();
        logic [7:0] body[$];
        set_config(16'd4, 17'd100, 8'h10, 8'h20);
        body = {8'h10};
        repeat (60) body.push_back(8'($urandom));
        body.push_back(8'h10);
        src_idle = 1'b0;
        hold_left <= 150;
        send_frame(body);
        repeat (12) send_item(mdk_pkg::OP_TICK, 8'($urandom));
        src_idle = 1'b1;
    endtask

    task automatic test_max_timeout();
        logic [7:0] body[$];
        set_config(16'd1, 17'h1FFFF, 8'hC3, 8'h3C);
        body = {8'hC3};
        send_frame(body);
        // Every tick asks for a ping; the pong age stays far below the largest timeout.
        src_idle = 1'b0;
        repeat (120) send_item(mdk_pkg::OP_TICK, 8'($urandom));
        src_idle = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [7:0] body[$];
        logic [7:0] t;
        int         sel;
        int         len;
        int         cut;
        tick_pct = 8;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_config(16'd1, 17'd1, 8'h00, 8'hFF);
                1: set_config(16'($urandom_range(2, 12)), 17'($urandom_range(4, 40)),
                              8'($urandom), 8'($urandom));
                2: set_config(16'd7, 17'd20, 8'h42, 8'h42);
                3: set_config(16'hFFFF, 17'h1FFFF, 8'hFF, 8'h00);
                default: set_config(16'($urandom_range(1, 16)), 17'($urandom_range(1, 60)),
                                    8'($urandom), 8'($urandom));
            endcase
            // The third phase runs with no idling on either side.
            src_idle = phase != 2;
            snk_idle <= phase != 2;
            items_done = 0;
            while (items_done < 260)
            begin
                sel = $urandom_range(99);
                if (sel < 70)
                begin
                    sel = $urandom_range(99);
                    if (sel < 35)
                        t = link_cfg.greeting_type_code;
                    else if (sel < 65)
                        t = link_cfg.pong_type_code;
                    else
                        t = 8'($urandom);
                    len = ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 6);
                    body.delete();
                    if (len > 0)
                        body.push_back(t);
                    for (int i = 2; i < len; i++)
                        body.push_back(body_byte_pick());
                    if (len > 1)
                        body.push_back(($urandom_range(3) != 0) ? t : 8'($urandom));
                    send_frame(body);
                end
                else if (sel < 85)
                    repeat ($urandom_range(1, 12)) send_item(mdk_pkg::OP_TICK, 8'($urandom));
                else if (sel < 93)
                    repeat ($urandom_range(1, 8)) send_item(mdk_pkg::OP_BYTE, body_byte_pick());
                else
                begin
                    cut = $urandom_range(1, mdk_pkg::END_LEN - 1);
                    if ($urandom_range(1) == 0)
                    begin
                        for (int i = 0; i < cut; i++)
                            send_item(mdk_pkg::OP_BYTE, mdk_pkg::START_MARK[i]);
                        send_item(mdk_pkg::OP_BYTE, 8'($urandom));
                    end
                    else
                    begin
                        // A spoilt end marker leaves the frame open for the traffic after it.
                        for (int i = 0; i < mdk_pkg::HIST_LEN; i++)
                            send_item(mdk_pkg::OP_BYTE, mdk_pkg::START_MARK[i]);
                        repeat ($urandom_range(1, 4)) send_item(mdk_pkg::OP_BYTE, 8'($urandom));
                        for (int i = 0; i < cut; i++)
                            send_item(mdk_pkg::OP_BYTE, mdk_pkg::END_MARK[i]);
                        send_item(mdk_pkg::OP_BYTE,
                                  mdk_pkg::END_MARK[cut] ^ 8'($urandom_range(1, 255)));
                    end
                end
            end
        end
        src_idle = 1'b1;
        snk_idle <= 1'b1;
        tick_pct = 0;
    endtask

    initial
    begin : result_check
        mdk_pkg::result_t want;
        mdk_pkg::result_t got;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                got.kind         = res_ch.kind;
                got.payload_byte = res_ch.payload_byte;
                got.frame_type   = res_ch.frame_type;
                got.type_ok      = res_ch.type_ok;
                got.last_of_step = res_ch.last_of_step;
                if (pending_results.size() == 0)
                    log_mismatch($sformatf("unexpected result: %s", show(got)));
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                        log_mismatch($sformatf("expected %s, got %s", show(want), show(got)));
                end
            end
            res_ch.ready <= (hold_left == 0) && !(snk_idle && $urandom_range(99) < 19);
        end
    end

    initial
    begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= mdk_pkg::CFG_PING_INTERVAL;
        cfg_data        <= '0;
        item_ch.valid   <= 1'b0;
        item_ch.opcode  <= mdk_pkg::OP_BYTE;
        item_ch.rx_byte <= 8'h00;

        link_cfg.ping_interval_ticks = mdk_pkg::PING_INTERVAL_RESET;
        link_cfg.pong_timeout_ticks  = mdk_pkg::PONG_TIMEOUT_RESET;
        link_cfg.greeting_type_code  = mdk_pkg::GREETING_TYPE_RESET;
        link_cfg.pong_type_code      = mdk_pkg::PONG_TYPE_RESET;
        framing          = 1'b0;
        body_len         = '0;
        open_type        = '0;
        keepalive_on     = 1'b0;
        ticks_since_ping = '0;
        pong_age         = '0;
        for (int i = 0; i < mdk_pkg::HIST_LEN; i++)
            recent[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_frame_cases();
        test_output_stall();
        test_max_timeout();
        test_random_traffic();
        drain_results();

        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
